FILE: hdl/ltpm_pkg.sv
// Package: shared types, constants and state encoding for the tile page mapper.
package ltpm_pkg;

  localparam int MaxPages = 64;
  localparam int SlotW = $clog2(MaxPages);
  localparam int CountW = SlotW + 1;
  localparam int KeyW = 30;

  typedef struct packed {
    logic [5:0]  beam_id;
    logic [7:0]  head_id;
    logic [15:0] tile_id;
  } req_t;

  typedef struct packed {
    logic [5:0]  page_id;
    logic        hit;
    logic        evicted;
    logic [5:0]  evicted_beam;
    logic [7:0]  evicted_head;
    logic [15:0] evicted_tile;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic clear;
  } ctrl_t;

endpackage

FILE: hdl/ltpm_datapath.sv
// Datapath: key tags, recency ranks, parallel match and victim choice.
module ltpm_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  ltpm_pkg::ctrl_t  ctrl,
  input  logic [6:0]       cfg_limit,
  input  ltpm_pkg::req_t   req,
  output ltpm_pkg::rsp_t   rsp
);

  logic [ltpm_pkg::KeyW-1:0]  key_r;
  logic [ltpm_pkg::KeyW-1:0]  tag_r [ltpm_pkg::MaxPages];
  logic [ltpm_pkg::SlotW-1:0] rank_r [ltpm_pkg::MaxPages];
  logic [ltpm_pkg::MaxPages-1:0] valid_r;
  logic [ltpm_pkg::CountW-1:0] fill_r;
  logic [ltpm_pkg::MaxPages-1:0] match_r;
  logic [ltpm_pkg::MaxPages-1:0] oldest_r;
  logic [ltpm_pkg::CountW-1:0] lim;
  logic hit_any;
  logic [ltpm_pkg::SlotW-1:0] hit_slot;
  logic [ltpm_pkg::SlotW-1:0] old_slot;
  logic [ltpm_pkg::SlotW-1:0] slot;
  logic [ltpm_pkg::SlotW-1:0] old_rank;
  logic filling;
  logic evict;
  logic [ltpm_pkg::KeyW-1:0] ev_key;
  logic [ltpm_pkg::SlotW-1:0] top_rank;
  logic [ltpm_pkg::SlotW-1:0] rank_in;

  always_comb begin
    if (cfg_limit == 7'd0) begin
      lim = ltpm_pkg::CountW'(1);
    end else if (32'(cfg_limit) > ltpm_pkg::MaxPages) begin
      lim = ltpm_pkg::CountW'(ltpm_pkg::MaxPages);
    end else begin
      lim = ltpm_pkg::CountW'(cfg_limit);
    end
  end

  // The victim holds rank fill-1, the largest among valid slots.
  assign top_rank = ltpm_pkg::SlotW'(fill_r - ltpm_pkg::CountW'(1));
  assign rank_in = ctrl.capture ? top_rank : '0;

  always_comb begin
    hit_any = |match_r;
    hit_slot = '0;
    old_slot = '0;
    for (int i = 0; i < ltpm_pkg::MaxPages; i++) begin
      if (match_r[i]) hit_slot = ltpm_pkg::SlotW'(i);
      if (oldest_r[i]) old_slot = ltpm_pkg::SlotW'(i);
    end
    filling = !hit_any && (fill_r < lim);
    evict = !hit_any && !filling && (fill_r != '0);
    if (hit_any) slot = hit_slot;
    else if (filling) slot = fill_r[ltpm_pkg::SlotW-1:0];
    else slot = old_slot;
    old_rank = filling ? fill_r[ltpm_pkg::SlotW-1:0] : rank_r[slot];
    ev_key = evict ? tag_r[slot] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      valid_r <= '0;
      fill_r <= '0;
    end else if (ctrl.update) begin
      if (filling || fill_r == '0) begin
        valid_r[slot] <= 1'b1;
        fill_r <= fill_r + ltpm_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      key_r <= {req.beam_id, req.head_id, req.tile_id};
      for (int i = 0; i < ltpm_pkg::MaxPages; i++) begin
        match_r[i] <= valid_r[i] && tag_r[i] == {req.beam_id, req.head_id, req.tile_id};
        oldest_r[i] <= valid_r[i] && rank_r[i] == rank_in;
      end
    end
    if (ctrl.update) begin
      for (int i = 0; i < ltpm_pkg::MaxPages; i++) begin
        if (valid_r[i] && ltpm_pkg::SlotW'(i) != slot && rank_r[i] < old_rank) begin
          rank_r[i] <= rank_r[i] + ltpm_pkg::SlotW'(1);
        end
      end
      rank_r[slot] <= '0;
      tag_r[slot] <= key_r;
      rsp.page_id <= 6'(slot);
      rsp.hit <= hit_any;
      rsp.evicted <= evict;
      rsp.evicted_beam <= ev_key[29:24];
      rsp.evicted_head <= ev_key[23:16];
      rsp.evicted_tile <= ev_key[15:0];
    end
  end

endmodule

FILE: hdl/ltpm_ctrl.sv
// Controller: sequences capture, lookup, update and result hand-off.
module ltpm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_we,
  output ltpm_pkg::ctrl_t ctrl
);

  ltpm_pkg::state_t state_r;
  ltpm_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ltpm_pkg::ST_IDLE:   if (in_valid) state_nxt = ltpm_pkg::ST_LOOKUP;
      ltpm_pkg::ST_LOOKUP: state_nxt = ltpm_pkg::ST_UPDATE;
      ltpm_pkg::ST_UPDATE: state_nxt = ltpm_pkg::ST_OUT;
      ltpm_pkg::ST_OUT: begin
        if (out_ready) state_nxt = in_valid ? ltpm_pkg::ST_LOOKUP : ltpm_pkg::ST_IDLE;
      end
      default: state_nxt = ltpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    ctrl = '0;
    ctrl.clear = cfg_we;
    unique case (state_r)
      ltpm_pkg::ST_IDLE: in_ready = 1'b1;
      ltpm_pkg::ST_LOOKUP: ;
      ltpm_pkg::ST_UPDATE: ctrl.update = 1'b1;
      ltpm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
      end
      default: ;
    endcase
    ctrl.capture = in_ready && in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltpm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/lru_tile_page_mapper_core.sv
// Top level: fully associative LRU map from a tile key to a physical page.
// Requests arrive on the in_ channel as (beam, head, tile) beats; each one
// gives exactly one result beat on the out_ channel with the page number,
// a hit flag and, when the table was full, the key that was evicted.
// A beat passes from acceptance to the result in these steps: capture
// the key and compare it against all 64 tags in parallel, settle the
// hit or victim slot, and rewrite the tag and age the ranks.
// The next request is taken in the cycle the result beat leaves, so a
// new request is never taken while an earlier one is still in progress.
// When the receiver stalls, the result holds and no new request is taken.
// Reset empties the table and sets the page limit to 64.
// A write on cfg_ sets the page limit and empties the table as well.
module lru_tile_page_mapper_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ltpm_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ltpm_pkg::rsp_t out_data,
  input  logic           cfg_we,
  input  logic [6:0]     cfg_data
);

  logic [6:0] limit_r;
  ltpm_pkg::ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 7'd64;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  ltpm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cfg_we(cfg_we), .ctrl(ctrl)
  );

  ltpm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .cfg_limit(limit_r),
    .req(in_data), .rsp(out_data)
  );

endmodule
